// ===== hdl/seg_isect_pkg.sv =====
// package for the segment intersection block: widths, status codes and
// transaction structs; used by every module under hdl, depends on nothing
package seg_isect_pkg;

   localparam int COORD_W = 16;                  // coordinate width, Q11.4
   localparam int DIFF_W  = COORD_W + 1;          // coordinate difference
   localparam int PROD_W  = 2 * DIFF_W;           // product of two differences
   localparam int DET_W   = PROD_W + 1;           // determinant and numerators
   localparam int NUM_W   = DET_W + DIFF_W;       // dividend of the point quotient
   localparam int QUO_W   = DIFF_W;               // quotient magnitude

   typedef enum logic [1:0] {
      STATUS_CROSS    = 2'd0,
      STATUS_PARALLEL = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax_start;
      logic signed [COORD_W-1:0] ay_start;
      logic signed [COORD_W-1:0] ax_end;
      logic signed [COORD_W-1:0] ay_end;
      logic signed [COORD_W-1:0] bx_start;
      logic signed [COORD_W-1:0] by_start;
      logic signed [COORD_W-1:0] bx_end;
      logic signed [COORD_W-1:0] by_end;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [COORD_W-1:0] cross_x;
      logic signed [COORD_W-1:0] cross_y;
   } rsp_type;

   // output of the determinant front end
   typedef struct packed {
      logic                      valid;
      logic signed [DET_W-1:0]   det;
      logic signed [DET_W-1:0]   tnum;
      logic signed [DET_W-1:0]   unum;
      logic signed [DIFF_W-1:0]  dx12;
      logic signed [DIFF_W-1:0]  dy12;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
   } front_type;

   // control and side data that travels with the divider
   typedef struct packed {
      logic                      valid;
      status_type                status;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic                      neg_x;
      logic                      neg_y;
      logic [DET_W-1:0]          dmag;
   } pipe_type;

   // one quotient lane of the divider
   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

endpackage

// ===== hdl/seg_isect_front.sv =====
// determinant front end: differences, products and the three determinants
// in three register stages; depends on seg_isect_pkg
module seg_isect_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  seg_isect_pkg::req_type        in_req,
   output seg_isect_pkg::front_type      out_front
);

   localparam int DIFF_W  = seg_isect_pkg::DIFF_W;
   localparam int PROD_W  = seg_isect_pkg::PROD_W;
   localparam int DET_W   = seg_isect_pkg::DET_W;
   localparam int COORD_W = seg_isect_pkg::COORD_W;

   logic                      v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0]  dx12_ff, dy12_ff, dx34_ff, dy34_ff, dx13_ff, dy13_ff;
   logic signed [COORD_W-1:0] x1_ff, y1_ff, x1b_ff, y1b_ff, x1c_ff, y1c_ff;
   logic signed [DIFF_W-1:0]  dx12b_ff, dy12b_ff, dx12c_ff, dy12c_ff;
   logic signed [PROD_W-1:0]  p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [DET_W-1:0]   det_ff, tnum_ff, unum_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 1: coordinate differences
   always_ff @(posedge clock) begin
      dx12_ff <= DIFF_W'(in_req.ax_start) - DIFF_W'(in_req.ax_end);
      dy12_ff <= DIFF_W'(in_req.ay_start) - DIFF_W'(in_req.ay_end);
      dx34_ff <= DIFF_W'(in_req.bx_start) - DIFF_W'(in_req.bx_end);
      dy34_ff <= DIFF_W'(in_req.by_start) - DIFF_W'(in_req.by_end);
      dx13_ff <= DIFF_W'(in_req.ax_start) - DIFF_W'(in_req.bx_start);
      dy13_ff <= DIFF_W'(in_req.ay_start) - DIFF_W'(in_req.by_start);
      x1_ff   <= in_req.ax_start;
      y1_ff   <= in_req.ay_start;
   end

   // stage 2: six products
   always_ff @(posedge clock) begin
      p1_ff    <= PROD_W'(dx12_ff) * PROD_W'(dy34_ff);
      p2_ff    <= PROD_W'(dy12_ff) * PROD_W'(dx34_ff);
      p3_ff    <= PROD_W'(dx13_ff) * PROD_W'(dy34_ff);
      p4_ff    <= PROD_W'(dy13_ff) * PROD_W'(dx34_ff);
      p5_ff    <= PROD_W'(dx13_ff) * PROD_W'(dy12_ff);
      p6_ff    <= PROD_W'(dy13_ff) * PROD_W'(dx12_ff);
      dx12b_ff <= dx12_ff;
      dy12b_ff <= dy12_ff;
      x1b_ff   <= x1_ff;
      y1b_ff   <= y1_ff;
   end

   // stage 3: determinant and both numerators
   always_ff @(posedge clock) begin
      det_ff   <= DET_W'(p1_ff) - DET_W'(p2_ff);
      tnum_ff  <= DET_W'(p3_ff) - DET_W'(p4_ff);
      unum_ff  <= DET_W'(p5_ff) - DET_W'(p6_ff);
      dx12c_ff <= dx12b_ff;
      dy12c_ff <= dy12b_ff;
      x1c_ff   <= x1b_ff;
      y1c_ff   <= y1b_ff;
   end

   assign out_front.valid = v3_ff;
   assign out_front.det   = det_ff;
   assign out_front.tnum  = tnum_ff;
   assign out_front.unum  = unum_ff;
   assign out_front.dx12  = dx12c_ff;
   assign out_front.dy12  = dy12c_ff;
   assign out_front.x1    = x1c_ff;
   assign out_front.y1    = y1c_ff;

endmodule

// ===== hdl/seg_isect_div_step.sv =====
// one registered step of the restoring divider, one quotient bit for
// both point lanes; depends on seg_isect_pkg
module seg_isect_div_step #(
   parameter int STEP_BIT = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  seg_isect_pkg::pipe_type      pipe_in,
   input  seg_isect_pkg::div_lane_type  lane_x_in,
   input  seg_isect_pkg::div_lane_type  lane_y_in,
   output seg_isect_pkg::pipe_type      pipe_out,
   output seg_isect_pkg::div_lane_type  lane_x_out,
   output seg_isect_pkg::div_lane_type  lane_y_out
);

   localparam int NUM_W = seg_isect_pkg::NUM_W;
   localparam int QUO_W = seg_isect_pkg::QUO_W;

   logic [NUM_W-1:0]            dsh;
   seg_isect_pkg::pipe_type     pipe_ff;
   seg_isect_pkg::div_lane_type lane_x_ff, lane_x_in2;
   seg_isect_pkg::div_lane_type lane_y_ff, lane_y_in2;

   assign dsh = NUM_W'(pipe_in.dmag) << STEP_BIT;

   // trial subtract of the shifted divisor
   always_comb begin
      lane_x_in2 = lane_x_in;
      lane_y_in2 = lane_y_in;
      if (lane_x_in.rem >= dsh) begin
         lane_x_in2.rem = lane_x_in.rem - dsh;
         lane_x_in2.quo = lane_x_in.quo | (QUO_W'(1) << STEP_BIT);
      end
      if (lane_y_in.rem >= dsh) begin
         lane_y_in2.rem = lane_y_in.rem - dsh;
         lane_y_in2.quo = lane_y_in.quo | (QUO_W'(1) << STEP_BIT);
      end
   end

   // stage register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff.valid <= 1'b0;
      end else begin
         pipe_ff.valid <= pipe_in.valid;
      end
      pipe_ff.status <= pipe_in.status;
      pipe_ff.x1     <= pipe_in.x1;
      pipe_ff.y1     <= pipe_in.y1;
      pipe_ff.neg_x  <= pipe_in.neg_x;
      pipe_ff.neg_y  <= pipe_in.neg_y;
      pipe_ff.dmag   <= pipe_in.dmag;
      lane_x_ff      <= lane_x_in2;
      lane_y_ff      <= lane_y_in2;
   end

   assign pipe_out   = pipe_ff;
   assign lane_x_out = lane_x_ff;
   assign lane_y_out = lane_y_ff;

endmodule

// ===== hdl/segment_intersection_top.sv =====
// top level of the segment intersection block: front end, range test,
// point numerators, divider chain and result register; depends on seg_isect_pkg,
// seg_isect_front and seg_isect_div_step
//
// Fully pipelined: a transaction is taken on every cycle that start is high
// (busy is always low) and its result appears on rsp_strobe/rsp_payload, one
// result per transaction in order. The pipeline holds three front-end stages
// (differences, products, determinants), a range and multiply stage, a sign
// stage, 17 restoring divider steps (one quotient bit each) and the result
// register. Results cannot be held off by the receiver.
module segment_intersection_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  seg_isect_pkg::req_type   req_payload,
   output logic                     rsp_strobe,
   output seg_isect_pkg::rsp_type   rsp_payload
);

   localparam int COORD_W = seg_isect_pkg::COORD_W;
   localparam int DET_W   = seg_isect_pkg::DET_W;
   localparam int NUM_W   = seg_isect_pkg::NUM_W;
   localparam int QUO_W   = seg_isect_pkg::QUO_W;

   seg_isect_pkg::front_type    front;
   logic signed [DET_W-1:0]     det, tnum, unum;
   logic                        det_neg, t_ok, u_ok;
   seg_isect_pkg::status_type   status_in;

   logic                        v4_ff;
   seg_isect_pkg::status_type   status4_ff;
   logic signed [DET_W-1:0]     det4_ff;
   logic signed [NUM_W-1:0]     nx4_ff, ny4_ff;
   logic signed [COORD_W-1:0]   x14_ff, y14_ff;

   seg_isect_pkg::pipe_type     stage_pipe [0:QUO_W];
   seg_isect_pkg::div_lane_type stage_x    [0:QUO_W];
   seg_isect_pkg::div_lane_type stage_y    [0:QUO_W];
   seg_isect_pkg::pipe_type     pipe5_ff;
   seg_isect_pkg::div_lane_type lane_x5_ff, lane_y5_ff;

   seg_isect_pkg::pipe_type     last;
   logic [QUO_W-1:0]            qx, qy;
   logic                        rsp_strobe_ff;
   seg_isect_pkg::rsp_type      rsp_ff, rsp_in;

   assign busy = 1'b0;

   seg_isect_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_req    (req_payload),
      .out_front (front)
   );

   // range test of t and u against the determinant
   assign det     = front.det;
   assign tnum    = front.tnum;
   assign unum    = front.unum;
   assign det_neg = det[DET_W-1];
   assign t_ok = det_neg ? (tnum <= 0 && tnum >= det) : (tnum >= 0 && tnum <= det);
   assign u_ok = det_neg ? (unum <= 0 && unum >= det) : (unum >= 0 && unum <= det);

   always_comb begin
      if (det == '0) begin
         status_in = seg_isect_pkg::STATUS_PARALLEL;
      end else if (t_ok && u_ok) begin
         status_in = seg_isect_pkg::STATUS_CROSS;
      end else begin
         status_in = seg_isect_pkg::STATUS_OUTSIDE;
      end
   end

   // stage 4: status and point numerators tnum * (x2 - x1)
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= front.valid;
      end
   end

   always_ff @(posedge clock) begin
      status4_ff <= status_in;
      det4_ff    <= det;
      nx4_ff     <= NUM_W'(tnum) * NUM_W'(-front.dx12);
      ny4_ff     <= NUM_W'(tnum) * NUM_W'(-front.dy12);
      x14_ff     <= front.x1;
      y14_ff     <= front.y1;
   end

   // stage 5: magnitudes and quotient signs
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe5_ff.valid <= 1'b0;
      end else begin
         pipe5_ff.valid <= v4_ff;
      end
      pipe5_ff.status <= status4_ff;
      pipe5_ff.x1     <= x14_ff;
      pipe5_ff.y1     <= y14_ff;
      pipe5_ff.neg_x  <= nx4_ff[NUM_W-1] ^ det4_ff[DET_W-1];
      pipe5_ff.neg_y  <= ny4_ff[NUM_W-1] ^ det4_ff[DET_W-1];
      pipe5_ff.dmag   <= det4_ff[DET_W-1] ? DET_W'(-det4_ff) : DET_W'(det4_ff);
      lane_x5_ff.rem  <= nx4_ff[NUM_W-1] ? NUM_W'(-nx4_ff) : NUM_W'(nx4_ff);
      lane_y5_ff.rem  <= ny4_ff[NUM_W-1] ? NUM_W'(-ny4_ff) : NUM_W'(ny4_ff);
      lane_x5_ff.quo  <= '0;
      lane_y5_ff.quo  <= '0;
   end

   assign stage_pipe[0] = pipe5_ff;
   assign stage_x[0]    = lane_x5_ff;
   assign stage_y[0]    = lane_y5_ff;

   // divider chain, most significant quotient bit first
   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      seg_isect_div_step #(
         .STEP_BIT (QUO_W - 1 - g)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .pipe_in    (stage_pipe[g]),
         .lane_x_in  (stage_x[g]),
         .lane_y_in  (stage_y[g]),
         .pipe_out   (stage_pipe[g+1]),
         .lane_x_out (stage_x[g+1]),
         .lane_y_out (stage_y[g+1])
      );
   end

   // sign fix and offset by the segment start
   assign last = stage_pipe[QUO_W];
   assign qx   = last.neg_x ? QUO_W'(-stage_x[QUO_W].quo) : stage_x[QUO_W].quo;
   assign qy   = last.neg_y ? QUO_W'(-stage_y[QUO_W].quo) : stage_y[QUO_W].quo;

   always_comb begin
      rsp_in.status  = last.status;
      rsp_in.cross_x = '0;
      rsp_in.cross_y = '0;
      if (last.status == seg_isect_pkg::STATUS_CROSS) begin
         rsp_in.cross_x = last.x1 + qx[COORD_W-1:0];
         rsp_in.cross_y = last.y1 + qy[COORD_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status != seg_isect_pkg::STATUS_CROSS
      |-> rsp_payload.cross_x == '0 && rsp_payload.cross_y == '0)
      else $error("point not zero for a non-crossing result");

   a_no_strobe_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   a_div_chain_valid: assert property (@(posedge clock) disable iff (reset)
      pipe5_ff.valid |-> ##(QUO_W + 1) rsp_strobe)
      else $error("transaction lost in the divider chain");

endmodule
